[hw/rtl/http_response_framer_core_defines.svh]
// Assertion macros shared by the response framer modules.
`ifndef HTTP_RESPONSE_FRAMER_CORE_DEFINES_SVH
`define HTTP_RESPONSE_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/hrf_pkg.sv]
package hrf_pkg;

   // Longest line, in bytes, that the parser accepts.
   localparam int unsigned MAX_LINE = 8192;
   localparam int unsigned LINE_POS_W = $clog2(MAX_LINE + 1);

   // Header key that selects the body length.
   localparam int unsigned KEY_LEN = 15;
   localparam int unsigned KEY_IDX_W = $clog2(KEY_LEN);

   localparam int unsigned LEN_W = 31;
   localparam int unsigned LEN_PROD_W = LEN_W + 4;
   localparam int unsigned STATUS_W = 10;
   localparam int unsigned STATUS_PROD_W = STATUS_W + 4;

   localparam logic [7:0] WS_MAX = 8'h20;
   localparam logic [7:0] LF = 8'h0a;
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [STATUS_W-1:0] STATUS_MAX = 10'd999;

   typedef enum logic [1:0] {
      ROLE_STATUS = 2'd0,
      ROLE_HEADER = 2'd1,
      ROLE_BODY = 2'd2,
      ROLE_IGNORED = 2'd3
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_STATUS_DIGIT = 3'd1,
      ERR_STATUS_MISSING = 3'd2,
      ERR_LENGTH = 3'd3,
      ERR_LINE_LONG = 3'd4
   } error_type;

   typedef enum logic [4:0] {
      PH_STATUS = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_BODY = 5'b00100,
      PH_DONE = 5'b01000,
      PH_ERROR = 5'b10000
   } phase_type;

   typedef enum logic [5:0] {
      ST_LEAD = 6'b000001,
      ST_PROTO = 6'b000010,
      ST_GAP = 6'b000100,
      ST_DIGITS = 6'b001000,
      ST_AFTER = 6'b010000,
      ST_BAD = 6'b100000
   } status_step_type;

   typedef enum logic [3:0] {
      LT_LEAD = 4'b0001,
      LT_DIGITS = 4'b0010,
      LT_TRAIL = 4'b0100,
      LT_BAD = 4'b1000
   } length_step_type;

   typedef struct packed {
      logic restart;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      role_type byte_role;
      logic [STATUS_W-1:0] status_code;
      logic [LEN_W-1:0] body_remaining;
      logic done_res;
      error_type error_code;
   } rsp_type;

   // Characters of the length header key, indexed from the line start.
   function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0: ch = 8'h43;
         4'd1: ch = 8'h6f;
         4'd2: ch = 8'h6e;
         4'd3: ch = 8'h74;
         4'd4: ch = 8'h65;
         4'd5: ch = 8'h6e;
         4'd6: ch = 8'h74;
         4'd7: ch = 8'h2d;
         4'd8: ch = 8'h4c;
         4'd9: ch = 8'h65;
         4'd10: ch = 8'h6e;
         4'd11: ch = 8'h67;
         4'd12: ch = 8'h74;
         4'd13: ch = 8'h68;
         4'd14: ch = 8'h3a;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[hw/rtl/hrf_parse.sv]
`include "http_response_framer_core_defines.svh"

module hrf_parse
   import hrf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic accept,
   input req_type req,
   output rsp_type rsp_next
);

   phase_type phase_ff, phase_in;
   status_step_type status_step_ff, status_step_in;
   logic [STATUS_W-1:0] status_value_ff, status_value_in;
   logic [LINE_POS_W-1:0] line_pos_ff, line_pos_in;
   logic prefix_ff, prefix_in;
   length_step_type length_step_ff, length_step_in;
   logic [LEN_W-1:0] length_accum_ff, length_accum_in;
   logic [LEN_W-1:0] body_left_ff, body_left_in;
   error_type error_ff, error_in;

   // State as seen by this beat, after an optional restart.
   phase_type cur_phase;
   status_step_type cur_status_step;
   logic [STATUS_W-1:0] cur_status_value;
   logic [LINE_POS_W-1:0] cur_line_pos;
   logic cur_prefix;
   length_step_type cur_length_step;
   logic [LEN_W-1:0] cur_length_accum;
   logic [LEN_W-1:0] cur_body_left;
   error_type cur_error;

   logic [7:0] rx;
   logic is_ws;
   logic is_digit;
   logic [3:0] digit;
   logic [STATUS_PROD_W-1:0] status_ext;
   logic [STATUS_PROD_W-1:0] status_prod;
   logic [LEN_PROD_W-1:0] length_ext;
   logic [LEN_PROD_W-1:0] length_prod;
   status_step_type status_step_upd;
   logic [STATUS_W-1:0] status_value_upd;
   length_step_type length_step_upd;
   logic [LEN_W-1:0] length_accum_upd;
   logic [LEN_W-1:0] body_dec;
   role_type role;

   assign rx = req.rx_byte;
   assign is_ws = (rx <= WS_MAX);
   assign is_digit = (rx >= CHAR_0) && (rx <= CHAR_9);
   assign digit = rx[3:0];

   // A restart replaces the stored state by its reset values.
   always_comb begin
      if (req.restart) begin
         cur_phase = PH_STATUS;
         cur_status_step = ST_LEAD;
         cur_status_value = '0;
         cur_line_pos = '0;
         cur_prefix = 1'b1;
         cur_length_step = LT_LEAD;
         cur_length_accum = '0;
         cur_body_left = '0;
         cur_error = ERR_NONE;
      end else begin
         cur_phase = phase_ff;
         cur_status_step = status_step_ff;
         cur_status_value = status_value_ff;
         cur_line_pos = line_pos_ff;
         cur_prefix = prefix_ff;
         cur_length_step = length_step_ff;
         cur_length_accum = length_accum_ff;
         cur_body_left = body_left_ff;
         cur_error = error_ff;
      end
   end

   // Decimal accumulation: value times ten as two shifts plus the digit.
   assign status_ext = {4'b0, cur_status_value};
   assign status_prod = (status_ext << 3) + (status_ext << 1) + {{(STATUS_PROD_W-4){1'b0}}, digit};
   assign length_ext = {4'b0, cur_length_accum};
   assign length_prod = (length_ext << 3) + (length_ext << 1) + {{(LEN_PROD_W-4){1'b0}}, digit};

   // Status token scanner.
   always_comb begin
      status_step_upd = cur_status_step;
      status_value_upd = cur_status_value;
      unique case (cur_status_step)
         ST_LEAD: begin
            if (!is_ws) status_step_upd = ST_PROTO;
         end
         ST_PROTO: begin
            if (is_ws) status_step_upd = ST_GAP;
         end
         ST_GAP, ST_DIGITS: begin
            if (is_ws) begin
               if (cur_status_step == ST_DIGITS) status_step_upd = ST_AFTER;
            end else if (!is_digit) begin
               status_step_upd = ST_BAD;
            end else if (status_prod > {4'b0, STATUS_MAX}) begin
               status_step_upd = ST_BAD;
            end else begin
               status_value_upd = status_prod[STATUS_W-1:0];
               status_step_upd = ST_DIGITS;
            end
         end
         ST_AFTER, ST_BAD: begin
         end
         default: begin
         end
      endcase
   end

   // Length value scanner.
   always_comb begin
      length_step_upd = cur_length_step;
      length_accum_upd = cur_length_accum;
      unique case (cur_length_step)
         LT_LEAD, LT_DIGITS: begin
            if (is_ws) begin
               if (cur_length_step == LT_DIGITS) length_step_upd = LT_TRAIL;
            end else if (!is_digit) begin
               length_step_upd = LT_BAD;
            end else if (length_prod[LEN_PROD_W-1:LEN_W] != '0) begin
               length_step_upd = LT_BAD;
            end else begin
               length_accum_upd = length_prod[LEN_W-1:0];
               length_step_upd = LT_DIGITS;
            end
         end
         LT_TRAIL: begin
            if (!is_ws) length_step_upd = LT_BAD;
         end
         LT_BAD: begin
         end
         default: begin
         end
      endcase
   end

   assign body_dec = cur_body_left - {{(LEN_W-1){1'b0}}, (cur_body_left != '0)};

   // Per-byte framing decision.
   always_comb begin
      phase_in = cur_phase;
      status_step_in = cur_status_step;
      status_value_in = cur_status_value;
      line_pos_in = cur_line_pos;
      prefix_in = cur_prefix;
      length_step_in = cur_length_step;
      length_accum_in = cur_length_accum;
      body_left_in = cur_body_left;
      error_in = cur_error;
      role = ROLE_IGNORED;
      priority if (cur_phase == PH_STATUS || cur_phase == PH_HEADER) begin
         role = (cur_phase == PH_STATUS) ? ROLE_STATUS : ROLE_HEADER;
         priority if (cur_line_pos >= LINE_POS_W'(MAX_LINE)) begin
            phase_in = PH_ERROR;
            error_in = ERR_LINE_LONG;
         end else if (rx == LF) begin
            if (cur_phase == PH_STATUS) begin
               priority if (cur_status_step == ST_BAD) begin
                  phase_in = PH_ERROR;
                  error_in = ERR_STATUS_DIGIT;
               end else if (cur_status_value == '0) begin
                  phase_in = PH_ERROR;
                  error_in = ERR_STATUS_MISSING;
               end else begin
                  phase_in = PH_HEADER;
               end
            end else begin
               // Commit the length at the end of a matching header line.
               if (cur_prefix && cur_line_pos >= LINE_POS_W'(KEY_LEN)) begin
                  if (length_step_upd == LT_DIGITS || length_step_upd == LT_TRAIL) begin
                     body_left_in = length_accum_upd;
                  end else begin
                     phase_in = PH_ERROR;
                     error_in = ERR_LENGTH;
                  end
               end
               // The empty line closes the headers.
               if (phase_in == PH_HEADER && cur_line_pos == LINE_POS_W'(1)) begin
                  phase_in = (body_left_in == '0) ? PH_DONE : PH_BODY;
               end
            end
            line_pos_in = '0;
            prefix_in = 1'b1;
            length_step_in = LT_LEAD;
            length_accum_in = '0;
         end else begin
            if (cur_phase == PH_STATUS) begin
               status_step_in = status_step_upd;
               status_value_in = status_value_upd;
            end else if (cur_line_pos < LINE_POS_W'(KEY_LEN)) begin
               if (rx != key_char(cur_line_pos[KEY_IDX_W-1:0])) prefix_in = 1'b0;
            end else if (cur_prefix) begin
               length_step_in = length_step_upd;
               length_accum_in = length_accum_upd;
            end
            line_pos_in = cur_line_pos + LINE_POS_W'(1);
         end
      end else if (cur_phase == PH_BODY) begin
         role = ROLE_BODY;
         body_left_in = body_dec;
         if (body_dec == '0) phase_in = PH_DONE;
      end else begin
         // Done and error phases ignore the byte and keep their state.
      end
   end

   // Result of this beat, taken from the updated state.
   always_comb begin
      rsp_next.data_byte = rx;
      rsp_next.byte_role = role;
      rsp_next.status_code = status_value_in;
      rsp_next.body_remaining = body_left_in;
      rsp_next.done_res = (phase_in == PH_DONE);
      rsp_next.error_code = error_in;
   end

   // Parse state advances once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS;
         status_step_ff <= ST_LEAD;
         status_value_ff <= '0;
         line_pos_ff <= '0;
         prefix_ff <= 1'b1;
         length_step_ff <= LT_LEAD;
         length_accum_ff <= '0;
         body_left_ff <= '0;
         error_ff <= ERR_NONE;
      end else if (accept) begin
         phase_ff <= phase_in;
         status_step_ff <= status_step_in;
         status_value_ff <= status_value_in;
         line_pos_ff <= line_pos_in;
         prefix_ff <= prefix_in;
         length_step_ff <= length_step_in;
         length_accum_ff <= length_accum_in;
         body_left_ff <= body_left_in;
         error_ff <= error_in;
      end
   end

   `HRF_ASSERT_NOW(a_error_phase, clock, reset, error_ff != ERR_NONE, phase_ff == PH_ERROR, "error latched outside error phase")
   `HRF_ASSERT_NEXT(a_done_sticky, clock, reset, accept && !req.restart && phase_ff == PH_DONE, phase_ff == PH_DONE && body_left_ff == '0, "done state left without restart")
   `HRF_ASSERT_NOW(a_line_bound, clock, reset, 1'b1, line_pos_ff <= LINE_POS_W'(MAX_LINE), "line position beyond buffer size")

endmodule

[hw/rtl/hrf_out_stage.sv]
`include "http_response_framer_core_defines.svh"

module hrf_out_stage
   import hrf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic in_load,
   input rsp_type in_data,
   output logic in_full,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data
);

   logic main_valid_ff, main_valid_in;
   logic skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic drain;

   assign drain = main_valid_ff && !rsp_stall;

   // Output register with one skid entry behind it.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      priority if (skid_valid_ff) begin
         if (drain) begin
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_load) begin
         if (!main_valid_ff || drain) begin
            main_in = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         main_valid_in = 1'b0;
      end else begin
         // Nothing arrives and nothing leaves.
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_full = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data = main_ff;

   `HRF_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff, "skid entry held with empty output register")
   `HRF_ASSERT_NEXT(a_stalled_holds, clock, reset, main_valid_ff && rsp_stall, main_valid_ff && $stable(main_ff), "stalled output beat changed")

endmodule

[hw/rtl/http_response_framer_core.sv]
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_stall  req_type: restart, rx_byte
// rsp      out        rsp_valid/rsp_stall  rsp_type: byte, role, status, length, done, error
//
// One byte per cycle while req_stall is low; each accepted beat's result is registered.
// The parse state and the output register are the only stages; the output
// register has one skid entry, so req_stall rises only once two results wait.
// Reset is synchronous and active high; it clears the parse state and empties
// the output stage. The restart bit in a beat clears the parse state for that beat.

module http_response_framer_core
   import hrf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data
);

   logic accept;
   logic out_full;
   rsp_type rsp_next;

   // A beat is taken whenever the skid entry is free.
   assign req_stall = out_full;
   assign accept = req_valid && !out_full;

   hrf_parse u_parse (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .rsp_next(rsp_next)
   );

   hrf_out_stage u_out (
      .clock(clock),
      .reset(reset),
      .in_load(accept),
      .in_data(rsp_next),
      .in_full(out_full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule
